// ===== rtl/gnss_binary_frame_receiver_core_defines.svh =====
// Assertion macros used by the frame receiver checker.
`ifndef GNSS_BINARY_FRAME_RECEIVER_CORE_DEFINES_SVH
`define GNSS_BINARY_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define GBFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbfr check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define GBFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbfr check failed");

`endif

// ===== rtl/gbfr_pkg.sv =====
// Shared types and constants for the binary GNSS frame receiver.
package gbfr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MAX_FRAME_BYTES = 2'd0;
  localparam cfg_idx_t CFG_SYNC_FIRST      = 2'd1;
  localparam cfg_idx_t CFG_SYNC_SECOND     = 2'd2;

  localparam byte_t MAX_FRAME_BYTES_RST = 8'd128;
  localparam byte_t SYNC_FIRST_RST      = 8'hB5;
  localparam byte_t SYNC_SECOND_RST     = 8'h62;

endpackage

// ===== rtl/gnss_binary_frame_receiver_core.sv =====
// Byte-serial binary GNSS frame receiver with 8-bit Fletcher checksum check.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | in        | in_valid / in_stall   | rx_byte
//  out     | out       | out_valid / out_stall | byte_taken .. frame_size
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word per cycle while in_stall is low: each byte passes through the state update
// into the output register, which holds one result per input word.
// in_stall is raised only while the output register is full and out_stall is high.
// cfg_ready is always high; rst is synchronous and restores register defaults
// and the sync hunt.
module gnss_binary_frame_receiver_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gbfr_pkg::byte_t     rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                byte_taken,
  output gbfr_pkg::byte_t     stored_byte,
  output gbfr_pkg::byte_t     byte_position,
  output logic                overflow_restart,
  output logic                frame_done,
  output logic                checksum_ok,
  output gbfr_pkg::byte_t     frame_class,
  output gbfr_pkg::byte_t     msg_ident,
  output gbfr_pkg::len_t      payload_length,
  output gbfr_pkg::byte_t     frame_size,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  gbfr_pkg::cfg_idx_t  cfg_index,
  input  gbfr_pkg::byte_t     cfg_data
);
  import gbfr_pkg::*;

  typedef enum logic [2:0] {
    ST_SYNC1   = 3'd0,
    ST_SYNC2   = 3'd1,
    ST_CLASS   = 3'd2,
    ST_IDENT   = 3'd3,
    ST_LENGTH  = 3'd4,
    ST_PAYLOAD = 3'd5,
    ST_CHECK   = 3'd6
  } rx_state_t;

  byte_t max_frame_bytes, sync_first, sync_second;

  rx_state_t state, state_next;
  byte_t     write_index, write_index_next;
  logic      len_hi, len_hi_next;
  len_t      payload_remaining, payload_remaining_next;
  logic      ck_hi, ck_hi_next;
  byte_t     sum_a, sum_a_next, sum_b, sum_b_next;
  byte_t     held_class, held_class_next, held_ident, held_ident_next;
  len_t      held_length, held_length_next;
  byte_t     first_check_byte, first_check_byte_next;

  logic  taken, overflow, done, ok;
  byte_t pos, acc_a;
  rx_state_t cur;

  logic accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  always_comb begin
    cur = state;
    overflow = 1'b0;
    taken = 1'b0;
    done = 1'b0;
    ok = 1'b0;
    pos = '0;
    state_next = state;
    write_index_next = write_index;
    len_hi_next = len_hi;
    payload_remaining_next = payload_remaining;
    ck_hi_next = ck_hi;
    held_class_next = held_class;
    held_ident_next = held_ident;
    held_length_next = held_length;
    first_check_byte_next = first_check_byte;
    acc_a = sum_a + rx_byte;
    sum_a_next = sum_a;
    sum_b_next = sum_b;

    if (write_index == max_frame_bytes) begin
      overflow = (state != ST_SYNC1);
      cur = ST_SYNC1;
    end

    unique case (cur)
      ST_SYNC2: begin
        if (rx_byte == sync_second) begin
          taken = 1'b1;
          state_next = ST_CLASS;
        end else begin
          state_next = ST_SYNC1;
        end
      end
      ST_CLASS: begin
        taken = 1'b1;
        held_class_next = rx_byte;
        sum_a_next = acc_a;
        sum_b_next = sum_b + acc_a;
        state_next = ST_IDENT;
      end
      ST_IDENT: begin
        taken = 1'b1;
        held_ident_next = rx_byte;
        sum_a_next = acc_a;
        sum_b_next = sum_b + acc_a;
        state_next = ST_LENGTH;
      end
      ST_LENGTH: begin
        taken = 1'b1;
        sum_a_next = acc_a;
        sum_b_next = sum_b + acc_a;
        if (!len_hi) begin
          held_length_next = {held_length[LEN_W-1:BYTE_W], rx_byte};
          len_hi_next = 1'b1;
        end else begin
          held_length_next = {rx_byte, held_length[BYTE_W-1:0]};
          payload_remaining_next = {rx_byte, held_length[BYTE_W-1:0]};
          state_next = ({rx_byte, held_length[BYTE_W-1:0]} == '0) ? ST_CHECK
                                                                  : ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        taken = 1'b1;
        sum_a_next = acc_a;
        sum_b_next = sum_b + acc_a;
        payload_remaining_next = payload_remaining - 1'b1;
        if (payload_remaining == len_t'(1)) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        taken = 1'b1;
        if (!ck_hi) begin
          first_check_byte_next = rx_byte;
          ck_hi_next = 1'b1;
        end else begin
          done = 1'b1;
          ok = (first_check_byte == sum_a) && (rx_byte == sum_b);
          state_next = ST_SYNC1;
        end
      end
      default: begin
        // first sync hunt; unused codes land here as well
        write_index_next = '0;
        state_next = ST_SYNC1;
        if (rx_byte == sync_first) begin
          taken = 1'b1;
          len_hi_next = 1'b0;
          payload_remaining_next = '0;
          ck_hi_next = 1'b0;
          sum_a_next = '0;
          sum_b_next = '0;
          held_length_next = '0;
          state_next = ST_SYNC2;
        end
      end
    endcase

    if (taken) begin
      pos = (cur == ST_SYNC1) ? '0 : write_index;
      write_index_next = pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_BYTES_RST;
      sync_first <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
      state <= ST_SYNC1;
      write_index <= '0;
      len_hi <= 1'b0;
      payload_remaining <= '0;
      ck_hi <= 1'b0;
      sum_a <= '0;
      sum_b <= '0;
      held_class <= '0;
      held_ident <= '0;
      held_length <= '0;
      first_check_byte <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MAX_FRAME_BYTES: max_frame_bytes <= cfg_data;
          CFG_SYNC_FIRST:      sync_first <= cfg_data;
          CFG_SYNC_SECOND:     sync_second <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        state <= state_next;
        write_index <= write_index_next;
        len_hi <= len_hi_next;
        payload_remaining <= payload_remaining_next;
        ck_hi <= ck_hi_next;
        sum_a <= sum_a_next;
        sum_b <= sum_b_next;
        held_class <= held_class_next;
        held_ident <= held_ident_next;
        held_length <= held_length_next;
        first_check_byte <= first_check_byte_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_taken <= taken;
      stored_byte <= taken ? rx_byte : '0;
      byte_position <= pos;
      overflow_restart <= overflow;
      frame_done <= done;
      checksum_ok <= ok;
      frame_class <= done ? held_class : '0;
      msg_ident <= done ? held_ident : '0;
      payload_length <= done ? held_length : '0;
      frame_size <= done ? write_index_next : '0;
    end
  end

endmodule

// ===== rtl/gbfr_checker.sv =====
// Port-level checker for the frame receiver, bound to the top level.
`include "gnss_binary_frame_receiver_core_defines.svh"

module gbfr_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic            byte_taken,
  input gbfr_pkg::byte_t stored_byte,
  input gbfr_pkg::byte_t byte_position,
  input logic            frame_done,
  input logic            checksum_ok,
  input gbfr_pkg::byte_t frame_class,
  input gbfr_pkg::len_t  payload_length,
  input gbfr_pkg::byte_t frame_size
);
  import gbfr_pkg::*;

  byte_t       pos_plus_one;
  logic [15:0] held_pair;
  logic        idle_zero;

  assign pos_plus_one = byte_position + 1'b1;
  assign held_pair    = {stored_byte, frame_size};
  assign idle_zero    = !checksum_ok && frame_class == '0 && payload_length == '0 &&
                        frame_size == '0;

  `GBFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(held_pair))
  `GBFR_ASSERT_NOW(a_no_stall_when_empty, !out_valid, !in_stall)
  `GBFR_ASSERT_NOW(a_idle_fields_zero, out_valid && !frame_done, idle_zero)
  `GBFR_ASSERT_NOW(a_done_size, out_valid && frame_done, byte_taken && pos_plus_one == frame_size)

endmodule

bind gnss_binary_frame_receiver_core gbfr_checker u_gbfr_checker (.*);
